// ===== rtl/fpta_pkg.sv =====
package fpta_pkg;

  localparam int unsigned SigW = 24;
  localparam int unsigned ExpW = 8;
  localparam int unsigned ManW = 23;
  localparam int unsigned SumW = 26;
  localparam int unsigned LzW  = 5;

  typedef struct packed {
    logic [ExpW-1:0] top;
    logic [SigW-1:0] sig_a;
    logic [SigW-1:0] sig_b;
    logic            sign_a;
    logic            sign_b;
  } align_t;

  typedef struct packed {
    logic            neg;
    logic [ExpW-1:0] top;
    logic [SigW:0]   mag;
  } mag_t;

  function automatic logic [LzW-1:0] lead_zeros(input logic [SigW-1:0] v);
    logic [LzW-1:0] n;
    logic           hit;
    n   = '0;
    hit = 1'b0;
    for (int i = SigW - 1; i >= 0; i--) begin
      if (!hit && v[i]) begin
        hit = 1'b1;
        n   = LzW'(SigW - 1 - i);
      end
    end
    return n;
  endfunction

endpackage

// ===== rtl/fp32_truncating_adder.sv =====
// Single-precision adder with truncation. Both operands always carry the
// implicit one (no denormals, infinities or NaNs); the smaller operand is
// aligned by a truncating right shift, the signed significands are added and
// the result is normalized with a full leading-one search, truncated, and its
// exponent wraps modulo 256. A zero sum gives +0. Four register stages
// (align, add, normalize, pack); one word enters every cycle while the output
// is not stalled. A stall at the output holds the whole pipeline.
module fp32_truncating_adder
  import fpta_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [31:0] a_bits_i,
  input  logic [31:0] b_bits_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [31:0] sum_bits_o
);

  logic [3:0] vld_q, vld_d;
  logic       adv;

  assign adv     = !(vld_q[3] && stall_i);
  assign stall_o = !adv;

  // stage 1: align
  align_t          s1_q, s1_d;
  logic [ExpW-1:0] ea, eb, sh;
  logic [SigW-1:0] ma, mb;
  always_comb begin
    ea = a_bits_i[30:23];
    eb = b_bits_i[30:23];
    ma = {1'b1, a_bits_i[22:0]};
    mb = {1'b1, b_bits_i[22:0]};
    s1_d.sign_a = a_bits_i[31];
    s1_d.sign_b = b_bits_i[31];
    if (ea > eb) begin
      sh = ea - eb;
      s1_d.top   = ea;
      s1_d.sig_a = ma;
      s1_d.sig_b = (sh >= ExpW'(SigW)) ? '0 : mb >> sh;
    end else begin
      sh = eb - ea;
      s1_d.top   = eb;
      s1_d.sig_b = mb;
      s1_d.sig_a = (sh >= ExpW'(SigW)) ? '0 : ma >> sh;
    end
  end

  // stage 2: signed add
  mag_t                   s2_q, s2_d;
  logic signed [SumW-1:0] va, vb, sum;
  always_comb begin
    va  = s1_q.sign_a ? -$signed({2'b00, s1_q.sig_a}) : $signed({2'b00, s1_q.sig_a});
    vb  = s1_q.sign_b ? -$signed({2'b00, s1_q.sig_b}) : $signed({2'b00, s1_q.sig_b});
    sum = va + vb;
    s2_d.neg = sum[SumW-1];
    s2_d.top = s1_q.top;
    s2_d.mag = sum[SumW-1] ? SigW'(0) + (SigW+1)'(-sum) : sum[SigW:0];
  end

  // stage 3: normalize
  logic            s3_zero_q, s3_zero_d, s3_neg_q;
  logic [ExpW-1:0] s3_exp_q, s3_exp_d;
  logic [SigW-1:0] s3_sig_q, s3_sig_d;
  logic [LzW-1:0]  lz;
  always_comb begin
    lz        = lead_zeros(s2_q.mag[SigW-1:0]);
    s3_zero_d = (s2_q.mag == '0);
    if (s2_q.mag[SigW]) begin
      s3_sig_d = s2_q.mag[SigW:1];
      s3_exp_d = s2_q.top + 8'd1;
    end else begin
      s3_sig_d = s2_q.mag[SigW-1:0] << lz;
      s3_exp_d = s2_q.top - ExpW'(lz);
    end
  end

  // stage 4: pack
  logic [31:0] res_q, res_d;
  assign res_d = s3_zero_q ? '0 : {s3_neg_q, s3_exp_q, s3_sig_q[ManW-1:0]};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q      <= s1_d;
      s2_q      <= s2_d;
      s3_zero_q <= s3_zero_d;
      s3_neg_q  <= s2_q.neg;
      s3_exp_q  <= s3_exp_d;
      s3_sig_q  <= s3_sig_d;
      res_q     <= res_d;
    end
  end

  assign vld_d = adv ? {vld_q[2:0], valid_i} : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign valid_o    = vld_q[3];
  assign sum_bits_o = res_q;

`ifndef NO_ASSERTIONS
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |=> $stable(vld_q)) else $error("pipeline moved while stalled");
  a_stall_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i)) else $error("stall without blocked output");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!stall_o && vld_q[2]) |=> valid_o) else $error("word lost in last stage");
`endif

endmodule

// ===== verif/fpta_checker.sv =====
`timescale 1ns / 1ps
module fpta_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic        stall_o,
  input  logic [31:0] a_bits_i,
  input  logic [31:0] b_bits_i,
  input  logic        valid_o,
  input  logic        stall_i,
  input  logic [31:0] sum_bits_o,
  output int          errors_o,
  output int          pending_o,
  output int          sums_seen_o
);

  logic [31:0] sum_q[$];

  // signed significand of one operand aligned to the larger exponent
  function automatic logic signed [26:0] aligned_sig(input logic [31:0] x,
                                                     input logic [7:0] top);
    logic [7:0]          shift;
    logic [23:0]         sig;
    logic signed [26:0]  v;
    shift = top - x[30:23];
    sig   = {1'b1, x[22:0]};
    v     = (shift >= 8'd24) ? 27'sd0 : $signed({3'b000, sig >> shift});
    return x[31] ? -v : v;
  endfunction

  function automatic logic [31:0] trunc_sum(input logic [31:0] a, input logic [31:0] b);
    logic [7:0]         top;
    logic signed [26:0] s;
    logic [26:0]        mag;
    logic [7:0]         ex;
    logic               neg;
    top = (a[30:23] > b[30:23]) ? a[30:23] : b[30:23];
    s   = aligned_sig(a, top) + aligned_sig(b, top);
    if (s == 0) return 32'h0;
    neg = s < 0;
    mag = neg ? -s : s;
    ex  = top;
    while (mag >= 27'h100_0000) begin
      mag = mag >> 1;
      ex  = ex + 8'd1;
    end
    while (mag < 27'h80_0000) begin
      mag = mag << 1;
      ex  = ex - 8'd1;
    end
    return {neg, ex, mag[22:0]};
  endfunction

  always @(posedge clk_i) begin
    logic [31:0] want;
    if (!rst_ni) begin
      errors_o    <= 0;
      sums_seen_o <= 0;
      sum_q.delete();
    end else begin
      if (valid_i && !stall_o) sum_q.push_back(trunc_sum(a_bits_i, b_bits_i));
      if (valid_o && !stall_i) begin
        sums_seen_o <= sums_seen_o + 1;
        if (sum_q.size() == 0) begin
          errors_o <= errors_o + 1;
          if (errors_o < 10) $display("unexpected word: sum %h", sum_bits_o);
        end else begin
          want = sum_q.pop_front();
          if (want !== sum_bits_o) begin
            errors_o <= errors_o + 1;
            if (errors_o < 10) begin
              $display("mismatch: sum expected %h got %h", want, sum_bits_o);
            end
          end
        end
      end
    end
  end

  always @(negedge clk_i) pending_o <= sum_q.size();

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

  logic        clk_i;
  logic        rst_ni;
  logic        valid_i;
  logic        stall_o;
  logic [31:0] a_bits_i;
  logic [31:0] b_bits_i;
  logic        valid_o;
  logic        stall_i;
  logic [31:0] sum_bits_o;
  int          errors;
  int          pending;
  int          sums_seen;
  int          cycles;
  int          sent;

  logic        hold_off;
  logic        feeding;

  fp32_truncating_adder u_dut (.*);

  fpta_checker u_chk (
    .clk_i, .rst_ni, .valid_i, .stall_o, .a_bits_i, .b_bits_i,
    .valid_o, .stall_i, .sum_bits_o,
    .errors_o(errors), .pending_o(pending), .sums_seen_o(sums_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > 200000) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 5))
      0: w[30:23] = 8'h00;
      1: w[30:23] = 8'hff;
      2: w[30:23] = 8'h7f + 8'($urandom_range(0, 2));
      default: ;
    endcase
    return w;
  endfunction

  // receiver: random stalls, one long hold-off while feeding
  initial begin
    int   n;
    logic held;
    held    = 1'b0;
    stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off && !held) begin
        held = 1'b1;
        stall_i <= 1'b1;
        repeat (200) @(posedge clk_i);
      end
      n = gap_len();
      if (n == 0 || !feeding) begin
        stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  task automatic send_word(input logic [31:0] a, input logic [31:0] b);
    int n;
    n = gap_len();
    if (n > 0) begin
      valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    valid_i  <= 1'b1;
    a_bits_i <= a;
    b_bits_i <= b;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    sent++;
  endtask

  initial begin
    logic [31:0] a;
    logic [31:0] b;
    int          wait_n;
    rst_ni   = 1'b0;
    valid_i  = 1'b0;
    a_bits_i = '0;
    b_bits_i = '0;
    hold_off = 1'b0;
    feeding  = 1'b1;
    sent     = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, cancellation, carry, far shifts, wraparound
    send_word(32'h0000_0000, 32'h0000_0000);
    send_word(32'hffff_ffff, 32'hffff_ffff);
    send_word(32'h7fff_ffff, 32'h7fff_ffff);
    send_word(32'h3f80_0000, 32'hbf80_0000);
    send_word(32'h3f80_0001, 32'hbf80_0000);
    send_word(32'h3fff_ffff, 32'h3fff_ffff);
    send_word(32'h3f80_0000, 32'h3f80_0000);
    send_word(32'h4b80_0000, 32'h3f80_0000);
    send_word(32'h4c00_0000, 32'h3f80_0000);
    send_word(32'h4b7f_ffff, 32'h3f80_0000);
    send_word(32'h7f80_0000, 32'h0000_0000);
    send_word(32'h8000_0000, 32'h0000_0001);
    send_word(32'h0080_0000, 32'h8000_0000);
    send_word(32'h7fc0_0000, 32'h7f40_0000);
    send_word(32'h0000_0001, 32'h8000_0000);
    send_word(32'hc000_0000, 32'h3fff_ffff);
    send_word(32'h5555_5555, 32'haaaa_aaaa);
    send_word(32'h3f80_0000, 32'hbf7f_ffff);

    for (int i = 0; i < 2000; i++) begin
      a = rand_word();
      case ($urandom_range(0, 3))
        0: b = {~a[31], a[30:23], a[22:0] ^ (23'h1 << $urandom_range(0, 22))};
        1: b = {$urandom_range(0, 1) == 1, a[30:23] + 8'($urandom_range(0, 3)),
                23'($urandom)};
        default: b = rand_word();
      endcase
      if (i == 500) hold_off = 1'b1;
      send_word(a, b);
    end
    valid_i <= 1'b0;
    feeding = 1'b0;

    wait_n = 0;
    while (pending != 0 && wait_n < 5000) begin
      @(posedge clk_i);
      wait_n++;
    end
    repeat (10) @(posedge clk_i);
    $display("sent %0d operand pairs, checked %0d sums under random gaps and stalls",
             sent, sums_seen);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
